// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertion helpers used by the controller
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `ASSERT_CLK(lbl, clk, rst_n, !(expr))

`endif

// ===== hdl/frqc_pkg.sv =====
// ----------------------------------------------------------------------------
// frqc_pkg
// types and constants of the flash ring queue controller
// ----------------------------------------------------------------------------
package frqc_pkg;

    // flash partition layout
    localparam int SECTOR_BYTES       = 4096;
    localparam int INDEX_RECORD_BYTES = 16;
    localparam int MAX_CAPACITY       = 4096;
    localparam int ADDRESS_BITS       = 24;
    localparam int JOURNAL_SLOTS      = SECTOR_BYTES / INDEX_RECORD_BYTES;

    // field widths
    localparam int PTR_W   = 12;
    localparam int CNT_W   = 13;
    localparam int BUF_W   = 20;
    localparam int OFS_W   = 12;
    localparam int ISZ_W   = 9;
    localparam int SEQ_W   = 8;
    localparam int BYTES_W = 21;
    localparam int FUNC_W  = 3;

    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(MAX_CAPACITY);

    // shared divider: dividend and divisor widths
    localparam int DIV_N = BUF_W;
    localparam int DIV_D = CNT_W;

    // apb register port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef logic [ADDRESS_BITS-1:0] t_addr;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PEEK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_ERASE  = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_COUNT  = 3'd6;

    // register indexes (word address)
    localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_CAPACITY     = 2'd1;
    localparam logic [1:0] REG_ITEM_SIZE    = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CNT_W-1:0]  item_count;
        logic [BUF_W-1:0]  buffer_bytes;
        logic [OFS_W-1:0]  item_offset;
    } t_req;

    typedef struct packed {
        logic               status;
        logic [CNT_W-1:0]   granted;
        t_addr              first_address;
        logic [BYTES_W-1:0] first_bytes;
        logic [BYTES_W-1:0] second_bytes;
        logic               journal_write;
        t_addr              journal_address;
        logic [CNT_W-1:0]   queued_count;
        logic [PTR_W-1:0]   read_position;
        logic [PTR_W-1:0]   write_position;
        logic [SEQ_W-1:0]   journal_sequence;
    } t_rsp;

    typedef struct packed {
        t_addr            base_address;
        logic [CNT_W-1:0] capacity;
        logic [ISZ_W-1:0] item_size;
    } t_cfg;

endpackage

// ===== hdl/frqc_if.sv =====
// ----------------------------------------------------------------------------
// frqc_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface frqc_req_if;
    import frqc_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface frqc_rsp_if;
    import frqc_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/frqc_cfg.sv =====
// ----------------------------------------------------------------------------
// frqc_cfg
// apb configuration registers: base address, capacity, item size
// ----------------------------------------------------------------------------
module frqc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [frqc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [frqc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [frqc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output frqc_pkg::t_cfg                  o_cfg
);
    import frqc_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address <= '0;
            r_cfg.capacity     <= CAP_MAX;
            r_cfg.item_size    <= ISZ_W'(16);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BASE_ADDRESS: r_cfg.base_address <= pwdata[ADDRESS_BITS-1:0];
                REG_CAPACITY:     r_cfg.capacity     <= pwdata[CNT_W-1:0];
                REG_ITEM_SIZE:    r_cfg.item_size    <= pwdata[ISZ_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (w_idx)
            REG_BASE_ADDRESS: prdata = APB_DATA_W'(r_cfg.base_address);
            REG_CAPACITY:     prdata = APB_DATA_W'(r_cfg.capacity);
            REG_ITEM_SIZE:    prdata = APB_DATA_W'(r_cfg.item_size);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== hdl/frqc_div.sv =====
// ----------------------------------------------------------------------------
// frqc_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module frqc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [frqc_pkg::DIV_N-1:0]  i_dividend,
    input  logic [frqc_pkg::DIV_D-1:0]  i_divisor,
    output logic                        o_done,
    output logic [frqc_pkg::DIV_N-1:0]  o_quotient,
    output logic [frqc_pkg::DIV_D-1:0]  o_remainder
);
    import frqc_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_N);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DIV_N-1:0]    r_quo;
    logic [DIV_D-1:0]    r_rem;
    logic [DIV_D-1:0]    r_div;
    logic [DIV_D:0]      w_shift;
    logic                w_ge;

    // partial remainder shifted by one dividend bit
    assign w_shift = {r_rem, r_quo[DIV_N-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIV_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_N-2:0], w_ge};
            r_rem <= w_ge ? DIV_D'(w_shift - {1'b0, r_div}) : w_shift[DIV_D-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== hdl/flash_ring_queue_controller.sv =====
// ----------------------------------------------------------------------------
// flash_ring_queue_controller
// index bookkeeping for a circular item log kept in flash
// ----------------------------------------------------------------------------
// Each request is handled alone: the request port is ready only while the
// sequencer is idle. Read oldest and peek newest also wait on the shared serial
// divider, which divides the buffer size by the item size in 20 steps. When the
// capacity register has been lowered to or below a stored pointer, the same
// divider reduces that pointer first, once for each pointer affected. One result
// transaction comes out per request through an output register, so the next
// request may be taken while the previous result still waits; a request only
// stalls at its final step when that register is still full.
// ----------------------------------------------------------------------------
module flash_ring_queue_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    frqc_req_if.sink                        i_req,
    frqc_rsp_if.source                      o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [frqc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [frqc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [frqc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import frqc_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE   = 15'd1,
        S_MODR   = 15'd2,
        S_MODR_W = 15'd4,
        S_MODW   = 15'd8,
        S_MODW_W = 15'd16,
        S_CLIP   = 15'd32,
        S_DIV    = 15'd64,
        S_DIV_W  = 15'd128,
        S_GRANT  = 15'd256,
        S_EXEC   = 15'd512,
        S_SEG    = 15'd1024,
        S_MUL_A  = 15'd2048,
        S_MUL_F  = 15'd4096,
        S_MUL_S  = 15'd8192,
        S_OUT    = 15'd16384
    } t_state;

    localparam t_addr SECTOR_OFS = t_addr'(SECTOR_BYTES);
    localparam t_addr RECORD_SZ  = t_addr'(INDEX_RECORD_BYTES);

    t_state r_state, n_state;

    // queue state
    logic [PTR_W-1:0] r_read_ptr;
    logic [PTR_W-1:0] r_write_ptr;
    logic [CNT_W-1:0] r_count;
    logic [SEQ_W-1:0] r_seq;

    // request and working registers
    t_req             r_req;
    logic [CNT_W-1:0] r_g;
    logic [PTR_W-1:0] r_start;
    logic [CNT_W-1:0] r_first;
    logic [CNT_W-1:0] r_second;
    logic [21:0]      r_prod;
    t_addr            r_faddr;
    logic [BYTES_W-1:0] r_fbytes;
    t_addr            r_jaddr;
    logic             r_status;
    logic             r_jw;
    logic             r_seg;

    // output register
    t_rsp r_rsp;
    logic r_rsp_valid;

    t_cfg             w_cfg;
    logic [CNT_W-1:0] w_cap;
    logic [ISZ_W-1:0] w_isz;
    logic [CNT_W-1:0] w_free;
    logic             w_rp_over;
    logic             w_wp_over;
    logic             w_rd_func;
    logic [8:0]       w_seq_inc;
    logic [SEQ_W-1:0] w_seq_next;
    logic [CNT_W-1:0] w_grant;
    logic [PTR_W-1:0] w_add_a;
    logic [CNT_W-1:0] w_add_b;
    logic [CNT_W:0]   w_sum;
    logic [CNT_W:0]   w_sum_red;
    logic [PTR_W-1:0] w_wrap;
    logic [CNT_W:0]   w_end;
    logic [CNT_W-1:0] w_first;
    logic [CNT_W-1:0] w_mul_a;
    logic [21:0]      w_prod;
    logic             w_out_load;
    logic             w_div_wait;
    logic             w_jaddr_clear;

    logic             w_div_start;
    logic [DIV_N-1:0] w_div_dividend;
    logic [DIV_D-1:0] w_div_divisor;
    logic             w_div_done;
    logic [DIV_N-1:0] w_div_quo;
    logic [DIV_D-1:0] w_div_rem;

    frqc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    frqc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (w_div_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    // effective capacity and item size
    always_comb begin
        if (w_cfg.capacity == '0) begin
            w_cap = CNT_W'(1);
        end else if (w_cfg.capacity > CAP_MAX) begin
            w_cap = CAP_MAX;
        end else begin
            w_cap = w_cfg.capacity;
        end
    end

    assign w_isz     = (w_cfg.item_size == '0) ? ISZ_W'(1) : w_cfg.item_size;
    assign w_free    = w_cap - r_count;
    assign w_rp_over = ({1'b0, r_read_ptr} >= w_cap);
    assign w_wp_over = ({1'b0, r_write_ptr} >= w_cap);
    assign w_rd_func = (r_req.func == FUNC_READ) || (r_req.func == FUNC_PEEK);

    // next journal slot
    assign w_seq_inc  = {1'b0, r_seq} + 9'd1;
    assign w_seq_next = (32'(w_seq_inc) >= JOURNAL_SLOTS) ? '0 : w_seq_inc[SEQ_W-1:0];

    // divider operand selection
    always_comb begin
        w_div_start    = 1'b0;
        w_div_dividend = '0;
        w_div_divisor  = w_cap;
        unique case (r_state)
            S_MODR: begin
                w_div_start    = w_rp_over;
                w_div_dividend = DIV_N'(r_read_ptr);
            end
            S_MODW: begin
                w_div_start    = w_wp_over;
                w_div_dividend = DIV_N'(r_write_ptr);
            end
            S_DIV: begin
                w_div_start    = w_rd_func;
                w_div_dividend = r_req.buffer_bytes;
                w_div_divisor  = DIV_D'(w_isz);
            end
            default: ;
        endcase
    end

    // grant per request
    always_comb begin
        unique case (r_req.func)
            FUNC_APPEND: w_grant = (r_req.item_count > w_free) ? w_free : r_req.item_count;
            FUNC_GET:    w_grant = ({1'b0, r_req.item_offset} < r_count) ? CNT_W'(1) : '0;
            FUNC_READ,
            FUNC_PEEK:   w_grant = (w_div_quo > BUF_W'(r_count)) ? r_count
                                                                 : w_div_quo[CNT_W-1:0];
            FUNC_DELETE: w_grant = (r_req.item_count > r_count) ? r_count : r_req.item_count;
            default:     w_grant = '0;
        endcase
    end

    // pointer advance with one wrap correction (sum stays below twice the capacity whenever a grant is made)
    always_comb begin
        w_add_a = r_read_ptr;
        w_add_b = '0;
        unique case (r_req.func)
            FUNC_APPEND: begin
                w_add_a = r_write_ptr;
                w_add_b = r_g;
            end
            FUNC_GET:    w_add_b = CNT_W'(r_req.item_offset);
            FUNC_PEEK:   w_add_b = r_count - r_g;
            FUNC_DELETE: w_add_b = r_g;
            default: ;
        endcase
    end

    assign w_sum     = {2'b0, w_add_a} + {1'b0, w_add_b};
    assign w_sum_red = (w_sum >= {1'b0, w_cap}) ? (w_sum - {1'b0, w_cap}) : w_sum;
    assign w_wrap    = w_sum_red[PTR_W-1:0];

    // split of the transfer at the ring end
    assign w_end   = {2'b0, r_start} + {1'b0, r_g};
    assign w_first = (w_end <= {1'b0, w_cap}) ? r_g : (w_cap - {1'b0, r_start});

    // shared multiplier: slot offset, then first and second segment bytes
    always_comb begin
        unique case (r_state)
            S_MUL_A: w_mul_a = {1'b0, r_start};
            S_MUL_F: w_mul_a = r_first;
            default: w_mul_a = r_second;
        endcase
    end

    assign w_prod = {9'b0, w_mul_a} * {13'b0, w_isz};

    assign w_out_load = (r_state == S_OUT) && (!r_rsp_valid || o_rsp.ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_req.valid) n_state = S_MODR;
            S_MODR:   n_state = w_rp_over ? S_MODR_W : S_MODW;
            S_MODR_W: if (w_div_done) n_state = S_MODW;
            S_MODW:   n_state = w_wp_over ? S_MODW_W : S_CLIP;
            S_MODW_W: if (w_div_done) n_state = S_CLIP;
            S_CLIP:   n_state = S_DIV;
            S_DIV:    n_state = w_rd_func ? S_DIV_W : S_GRANT;
            S_DIV_W:  if (w_div_done) n_state = S_GRANT;
            S_GRANT:  n_state = S_EXEC;
            S_EXEC:   n_state = S_SEG;
            S_SEG:    n_state = S_MUL_A;
            S_MUL_A:  n_state = S_MUL_F;
            S_MUL_F:  n_state = S_MUL_S;
            S_MUL_S:  n_state = S_OUT;
            S_OUT:    if (w_out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state and queue bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_read_ptr  <= '0;
            r_write_ptr <= '0;
            r_count     <= '0;
            r_seq       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_MODR_W: if (w_div_done) r_read_ptr <= w_div_rem[PTR_W-1:0];
                S_MODW_W: if (w_div_done) r_write_ptr <= w_div_rem[PTR_W-1:0];
                S_CLIP:   if (r_count > w_cap) r_count <= w_cap;
                S_EXEC: begin
                    unique case (r_req.func)
                        FUNC_APPEND: begin
                            if (r_g != '0) begin
                                r_count     <= r_count + r_g;
                                r_write_ptr <= w_wrap;
                                r_seq       <= w_seq_next;
                            end
                        end
                        FUNC_DELETE: begin
                            if (r_g != '0) begin
                                r_count    <= r_count - r_g;
                                r_read_ptr <= w_wrap;
                                r_seq      <= w_seq_next;
                            end
                        end
                        FUNC_ERASE: begin
                            r_read_ptr  <= '0;
                            r_write_ptr <= '0;
                            r_count     <= '0;
                            r_seq       <= '0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            // result register handshake
            if (w_out_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_req <= i_req.payload;
        end
        unique case (r_state)
            S_GRANT: r_g <= w_grant;
            S_EXEC: begin
                // appends start at the write pointer, everything else at the summed pointer
                r_start <= (r_req.func == FUNC_APPEND) ? r_write_ptr : w_wrap;
                unique case (r_req.func)
                    FUNC_APPEND: begin
                        r_status <= (r_g == '0);
                        r_seg    <= (r_g != '0);
                        r_jw     <= (r_g != '0);
                    end
                    FUNC_GET,
                    FUNC_READ,
                    FUNC_PEEK: begin
                        r_status <= (r_g == '0);
                        r_seg    <= (r_g != '0);
                        r_jw     <= 1'b0;
                    end
                    FUNC_DELETE: begin
                        r_status <= 1'b0;
                        r_seg    <= 1'b0;
                        r_jw     <= (r_g != '0);
                    end
                    FUNC_ERASE: begin
                        r_status <= 1'b0;
                        r_seg    <= 1'b0;
                        r_jw     <= 1'b1;
                    end
                    FUNC_COUNT: begin
                        r_status <= 1'b0;
                        r_seg    <= 1'b0;
                        r_jw     <= 1'b0;
                    end
                    default: begin
                        r_status <= 1'b1;
                        r_seg    <= 1'b0;
                        r_jw     <= 1'b0;
                    end
                endcase
            end
            S_SEG: begin
                if (r_seg) begin
                    r_first  <= w_first;
                    r_second <= r_g - w_first;
                end else begin
                    r_start  <= '0;
                    r_first  <= '0;
                    r_second <= '0;
                end
            end
            S_MUL_A: begin
                r_prod  <= w_prod;
                r_jaddr <= r_jw ? (w_cfg.base_address + t_addr'(r_seq) * RECORD_SZ) : '0;
            end
            S_MUL_F: begin
                r_faddr <= r_seg ? (w_cfg.base_address + SECTOR_OFS + t_addr'(r_prod)) : '0;
                r_prod  <= w_prod;
            end
            S_MUL_S: begin
                r_fbytes <= r_prod[BYTES_W-1:0];
                r_prod   <= w_prod;
            end
            S_OUT: begin
                if (w_out_load) begin
                    r_rsp.status           <= r_status;
                    r_rsp.granted          <= r_g;
                    r_rsp.first_address    <= r_faddr;
                    r_rsp.first_bytes      <= r_fbytes;
                    r_rsp.second_bytes     <= r_prod[BYTES_W-1:0];
                    r_rsp.journal_write    <= r_jw;
                    r_rsp.journal_address  <= r_jaddr;
                    r_rsp.queued_count     <= r_count;
                    r_rsp.read_position    <= r_read_ptr;
                    r_rsp.write_position   <= r_write_ptr;
                    r_rsp.journal_sequence <= r_seq;
                end
            end
            default: ;
        endcase
    end

    // channel outputs
    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    // check helpers
    assign w_div_wait    = (r_state == S_MODR_W) || (r_state == S_MODW_W)
                        || (r_state == S_DIV_W);
    assign w_jaddr_clear = o_rsp.payload.journal_write
                        || (o_rsp.payload.journal_address == '0);

    // checks
    `include "assert_macros.svh"

    `ASSERT_CLK(a_accept_starts, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> r_state == S_MODR)
    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CAP_MAX)
    `ASSERT_CLK(a_div_done_waits, i_clk, i_rst_n, w_div_done |-> w_div_wait)
    `ASSERT_CLK(a_journal_addr_idle, i_clk, i_rst_n, o_rsp.valid |-> w_jaddr_clear)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the flash ring queue controller: a directed table
// walks the corner requests, then randomized bursts run under several register
// settings, with every result transaction compared against its table entry or a local
// model of the pointer, count and journal bookkeeping
// ----------------------------------------------------------------------------
module tb;
    import frqc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT       = 800000;
    localparam int LONG_HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES       = 120;
    localparam int MAX_PRINTED_ERRS  = 40;

    typedef struct {
        t_req rq;
        bit   typed;
        t_rsp want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    frqc_req_if req_ch ();
    frqc_rsp_if rsp_ch ();

    flash_ring_queue_controller DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model copy of the register file and the queue index
    t_addr            cfg_base = '0;
    logic [CNT_W-1:0] cfg_cap  = CNT_W'(MAX_CAPACITY);
    logic [ISZ_W-1:0] cfg_isz  = ISZ_W'(16);
    logic [PTR_W-1:0] ring_rd   = '0;
    logic [PTR_W-1:0] ring_wr   = '0;
    logic [CNT_W-1:0] ring_held = '0;
    logic [SEQ_W-1:0] ring_seq  = '0;

    t_rsp      index_results_due[$];
    t_stim_row stim_rows[$];

    int unsigned n_errors      = 0;
    int unsigned n_directed    = 0;
    int unsigned n_random      = 0;
    int unsigned n_checked     = 0;
    int unsigned n_journal     = 0;
    int unsigned n_wrapped     = 0;
    int unsigned n_settings    = 0;
    int unsigned cycle_count   = 0;
    bit          long_hold_req    = 1'b0;
    bit          long_hold_active = 1'b0;

    // ring size and item size as the block applies them
    function automatic int unsigned ring_cap();
        if (cfg_cap == '0)
            return 1;
        if (cfg_cap > CAP_MAX)
            return MAX_CAPACITY;
        return cfg_cap;
    endfunction

    function automatic int unsigned ring_isz();
        return (cfg_isz == '0) ? 1 : cfg_isz;
    endfunction

    // journal slot sequence wraps at the number of slots in the index sector
    function automatic logic [SEQ_W-1:0] next_journal_slot(input logic [SEQ_W-1:0] s);
        int unsigned n;
        n = s + 1;
        if (n >= JOURNAL_SLOTS)
            n = 0;
        return SEQ_W'(n);
    endfunction

    // index update for one request, returns the expected result
    function automatic t_rsp ring_index_step(input t_req rq);
        t_rsp        r;
        int unsigned cap;
        int unsigned isz;
        int unsigned g;
        int unsigned start;
        int unsigned first_n;
        bit          seg;
        r     = '0;
        seg   = 1'b0;
        g     = 0;
        start = 0;
        cap   = ring_cap();
        isz   = ring_isz();
        // pointers and count folded into a lowered capacity
        ring_rd = PTR_W'(ring_rd % cap);
        ring_wr = PTR_W'(ring_wr % cap);
        if (ring_held > cap)
            ring_held = CNT_W'(cap);
        case (rq.func)
            FUNC_APPEND: begin
                g = rq.item_count;
                if (g > cap - ring_held)
                    g = cap - ring_held;
                if (g == 0) begin
                    r.status = 1'b1;
                end else begin
                    start     = ring_wr;
                    seg       = 1'b1;
                    ring_held = CNT_W'(ring_held + g);
                    ring_wr   = PTR_W'((ring_wr + g) % cap);
                    ring_seq  = next_journal_slot(ring_seq);
                    r.journal_write   = 1'b1;
                    r.journal_address = t_addr'(cfg_base + ring_seq * INDEX_RECORD_BYTES);
                end
            end
            FUNC_GET: begin
                if (rq.item_offset < ring_held) begin
                    g     = 1;
                    start = (ring_rd + rq.item_offset) % cap;
                    seg   = 1'b1;
                end else begin
                    r.status = 1'b1;
                end
            end
            FUNC_READ, FUNC_PEEK: begin
                g = rq.buffer_bytes / isz;
                if (g > ring_held)
                    g = ring_held;
                if (g == 0) begin
                    r.status = 1'b1;
                end else begin
                    start = (rq.func == FUNC_READ) ? ring_rd : (ring_rd + (ring_held - g)) % cap;
                    seg   = 1'b1;
                end
            end
            FUNC_DELETE: begin
                g = rq.item_count;
                if (g > ring_held)
                    g = ring_held;
                if (g > 0) begin
                    ring_held = CNT_W'(ring_held - g);
                    ring_rd   = PTR_W'((ring_rd + g) % cap);
                    ring_seq  = next_journal_slot(ring_seq);
                    r.journal_write   = 1'b1;
                    r.journal_address = t_addr'(cfg_base + ring_seq * INDEX_RECORD_BYTES);
                end
            end
            FUNC_ERASE: begin
                ring_rd   = '0;
                ring_wr   = '0;
                ring_held = '0;
                ring_seq  = '0;
                r.journal_write   = 1'b1;
                r.journal_address = cfg_base;
            end
            FUNC_COUNT: begin
            end
            default: begin
                r.status = 1'b1;
            end
        endcase
        if (rq.func != FUNC_ERASE && rq.func != FUNC_COUNT && rq.func != FUNC_UNUSED)
            r.granted = CNT_W'(g);
        // data segments, split where the ring wraps
        if (seg) begin
            first_n = (start + g <= cap) ? g : cap - start;
            r.first_address = t_addr'(cfg_base + SECTOR_BYTES + start * isz);
            r.first_bytes   = BYTES_W'(first_n * isz);
            r.second_bytes  = BYTES_W'((g - first_n) * isz);
        end
        r.queued_count     = ring_held;
        r.read_position    = ring_rd;
        r.write_position   = ring_wr;
        r.journal_sequence = ring_seq;
        return r;
    endfunction

    function automatic t_rsp rsp_of(input logic st, input int unsigned granted,
                                    input int unsigned faddr, input int unsigned fbytes,
                                    input int unsigned sbytes, input logic jw,
                                    input int unsigned jaddr, input int unsigned queued,
                                    input int unsigned rp, input int unsigned wp,
                                    input int unsigned sq);
        t_rsp r;
        r.status           = st;
        r.granted          = CNT_W'(granted);
        r.first_address    = t_addr'(faddr);
        r.first_bytes      = BYTES_W'(fbytes);
        r.second_bytes     = BYTES_W'(sbytes);
        r.journal_write    = jw;
        r.journal_address  = t_addr'(jaddr);
        r.queued_count     = CNT_W'(queued);
        r.read_position    = PTR_W'(rp);
        r.write_position   = PTR_W'(wp);
        r.journal_sequence = SEQ_W'(sq);
        return r;
    endfunction

    task automatic add_row(input logic [FUNC_W-1:0] fn, input int unsigned cnt,
                           input int unsigned buf_b, input int unsigned ofs,
                           input bit typed, input t_rsp want);
        t_stim_row row;
        row.rq.func         = fn;
        row.rq.item_count   = CNT_W'(cnt);
        row.rq.buffer_bytes = BUF_W'(buf_b);
        row.rq.item_offset  = OFS_W'(ofs);
        row.typed           = typed;
        row.want            = want;
        stim_rows.push_back(row);
    endtask

    // random request, mostly sized to the ring so the queue fills and drains
    function automatic t_req make_request();
        t_req        rq;
        int unsigned cap;
        int unsigned pick;
        int unsigned span;
        cap             = ring_cap();
        rq.func         = FUNC_W'($urandom);
        rq.item_count   = CNT_W'($urandom);
        rq.buffer_bytes = BUF_W'($urandom);
        rq.item_offset  = OFS_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30)
            rq.func = FUNC_APPEND;
        else if (pick < 45)
            rq.func = FUNC_GET;
        else if (pick < 60)
            rq.func = FUNC_READ;
        else if (pick < 70)
            rq.func = FUNC_PEEK;
        else if (pick < 90)
            rq.func = FUNC_DELETE;
        else if (pick < 93)
            rq.func = FUNC_ERASE;
        else if (pick < 97)
            rq.func = FUNC_COUNT;
        else
            rq.func = FUNC_UNUSED;
        if ($urandom_range(0, 7) != 0) begin
            if (rq.func == FUNC_APPEND)
                rq.item_count = CNT_W'($urandom_range(0, cap / 3 + 1));
            else
                rq.item_count = CNT_W'($urandom_range(0, ring_held / 2 + 2));
            span = ring_isz() * (ring_held + 2);
            if (span > 20'hFFFFF)
                span = 20'hFFFFF;
            rq.buffer_bytes = BUF_W'($urandom_range(0, span));
            rq.item_offset  = OFS_W'($urandom_range(0, ring_held + 1));
        end
        return rq;
    endfunction

    // offer one request and wait until it is accepted
    task automatic send_request(input t_req rq, input bit typed, input t_rsp want);
        t_rsp predicted;
        req_ch.valid   <= 1'b1;
        req_ch.payload <= rq;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1)
            @(posedge i_clk);
        predicted = ring_index_step(rq);
        index_results_due.push_back(typed ? want : predicted);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1)
            @(posedge i_clk);
        case (idx)
            REG_BASE_ADDRESS: cfg_base = t_addr'(val);
            REG_CAPACITY:     cfg_cap  = CNT_W'(val);
            REG_ITEM_SIZE:    cfg_isz  = ISZ_W'(val);
            default: ;
        endcase
    endtask

    // new register setting once the block has gone idle
    task automatic apply_ring_setup(input int unsigned base, input int unsigned cap,
                                    input int unsigned isz);
        while (index_results_due.size() != 0 || req_ch.ready !== 1'b1)
            @(posedge i_clk);
        apb_write(REG_BASE_ADDRESS, APB_DATA_W'(base));
        apb_write(REG_CAPACITY, APB_DATA_W'(cap));
        apb_write(REG_ITEM_SIZE, APB_DATA_W'(isz));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
    endtask

    // random requests in bursts with gaps between them
    task automatic run_random_phase(input int unsigned n_items, input bit with_hold);
        int unsigned i;
        int unsigned b;
        int unsigned burst;
        int unsigned gap;
        i = 0;
        while (i < n_items) begin
            burst = $urandom_range(1, 24);
            for (b = 0; b < burst && i < n_items; b++) begin
                if (with_hold && i == 60)
                    long_hold_req = 1'b1;
                send_request(make_request(), 1'b0, '0);
                i++;
                n_random++;
            end
            if (long_hold_req || long_hold_active || $urandom_range(0, 3) == 0)
                gap = 0;
            else
                gap = $urandom_range(1, 30);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        req_ch.valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        n_errors++;
        if (n_errors <= MAX_PRINTED_ERRS)
            $display("mismatch on result %0d: %s got 0x%0h want 0x%0h",
                     n_checked, field, got, want);
    endtask

    task automatic compare_result(input t_rsp got, input t_rsp want);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.granted !== want.granted)
            report_mismatch("granted", got.granted, want.granted);
        if (got.first_address !== want.first_address)
            report_mismatch("first_address", got.first_address, want.first_address);
        if (got.first_bytes !== want.first_bytes)
            report_mismatch("first_bytes", got.first_bytes, want.first_bytes);
        if (got.second_bytes !== want.second_bytes)
            report_mismatch("second_bytes", got.second_bytes, want.second_bytes);
        if (got.journal_write !== want.journal_write)
            report_mismatch("journal_write", got.journal_write, want.journal_write);
        if (got.journal_address !== want.journal_address)
            report_mismatch("journal_address", got.journal_address, want.journal_address);
        if (got.queued_count !== want.queued_count)
            report_mismatch("queued_count", got.queued_count, want.queued_count);
        if (got.read_position !== want.read_position)
            report_mismatch("read_position", got.read_position, want.read_position);
        if (got.write_position !== want.write_position)
            report_mismatch("write_position", got.write_position, want.write_position);
        if (got.journal_sequence !== want.journal_sequence)
            report_mismatch("journal_sequence", got.journal_sequence, want.journal_sequence);
    endtask

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (index_results_due.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_PRINTED_ERRS)
                    $display("result transaction with nothing outstanding");
            end else begin
                if (index_results_due[0].journal_write)
                    n_journal++;
                if (index_results_due[0].second_bytes != '0)
                    n_wrapped++;
                compare_result(rsp_ch.payload, index_results_due.pop_front());
                n_checked++;
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin : rsp_stall_gen
        int unsigned mode_len;
        int unsigned pct;
        int unsigned hold_n;
        rsp_ch.ready = 1'b0;
        forever begin
            if (long_hold_req) begin
                long_hold_active = 1'b1;
                long_hold_req    = 1'b0;
                rsp_ch.ready <= 1'b0;
                for (hold_n = 0; hold_n < LONG_HOLD_CYCLES; hold_n++)
                    @(posedge i_clk);
                long_hold_active = 1'b0;
            end
            mode_len = $urandom_range(1, 60);
            case ($urandom_range(0, 3))
                0, 1:    pct = 100;
                2:       pct = 50;
                default: pct = 15;
            endcase
            repeat (mode_len) begin
                rsp_ch.ready <= ($urandom_range(1, 100) <= pct);
                @(posedge i_clk);
            end
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // main sequence
    initial begin : main_seq
        int unsigned k;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;

        // directed rows under the reset register values
        add_row(FUNC_COUNT, 0, 0, 0, 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(FUNC_READ, 0, 1000, 0, 1'b1, rsp_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(FUNC_PEEK, 8191, 1000, 4095, 1'b1, rsp_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(FUNC_GET, 0, 0, 0, 1'b1, rsp_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(FUNC_DELETE, 5, 0, 0, 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(FUNC_UNUSED, 8191, 20'hFFFFF, 4095, 1'b1,
                rsp_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(FUNC_ERASE, 0, 0, 0, 1'b1, rsp_of(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        add_row(FUNC_APPEND, 4096, 0, 0, 1'b1,
                rsp_of(0, 4096, 4096, 65536, 0, 1, 16, 4096, 0, 0, 1));
        add_row(FUNC_APPEND, 1, 0, 0, 1'b1, rsp_of(1, 0, 0, 0, 0, 0, 0, 4096, 0, 0, 1));
        add_row(FUNC_COUNT, 8191, 20'hFFFFF, 4095, 1'b1,
                rsp_of(0, 0, 0, 0, 0, 0, 0, 4096, 0, 0, 1));
        add_row(FUNC_GET, 0, 0, 4095, 1'b0, '0);
        add_row(FUNC_READ, 0, 20'hFFFFF, 0, 1'b0, '0);
        add_row(FUNC_PEEK, 0, 15, 0, 1'b0, '0);
        add_row(FUNC_PEEK, 0, 48, 0, 1'b0, '0);
        add_row(FUNC_DELETE, 4095, 0, 0, 1'b0, '0);
        add_row(FUNC_APPEND, 8191, 0, 0, 1'b0, '0);
        add_row(FUNC_GET, 0, 0, 4095, 1'b0, '0);
        add_row(FUNC_READ, 0, 32, 0, 1'b0, '0);
        add_row(FUNC_PEEK, 0, 20'hFFFFF, 0, 1'b0, '0);
        add_row(FUNC_DELETE, 0, 0, 0, 1'b0, '0);
        add_row(FUNC_DELETE, 8191, 0, 0, 1'b0, '0);
        add_row(FUNC_GET, 0, 0, 0, 1'b0, '0);
        add_row(FUNC_APPEND, 0, 0, 0, 1'b0, '0);
        add_row(FUNC_APPEND, 100, 0, 0, 1'b0, '0);
        add_row(FUNC_ERASE, 8191, 20'hFFFFF, 4095, 1'b0, '0);

        // reset
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < stim_rows.size(); k++) begin
            send_request(stim_rows[k].rq, stim_rows[k].typed, stim_rows[k].want);
            n_directed++;
        end
        req_ch.valid <= 1'b0;

        // random phases, each under its own register setting
        apply_ring_setup(0, MAX_CAPACITY, 16);
        run_random_phase(300, 1'b1);
        apply_ring_setup(24'hFFFFFF, 1, 1);
        run_random_phase(150, 1'b0);
        apply_ring_setup($urandom & 24'hFFFFFF, 0, 0);
        run_random_phase(100, 1'b0);
        apply_ring_setup($urandom & 24'hFFFFFF, 13'h1FFF, 511);
        run_random_phase(300, 1'b0);
        // capacity dropped while the ring still holds items
        apply_ring_setup($urandom & 24'hFFFFFF, $urandom_range(2, 64), 256);
        run_random_phase(250, 1'b0);
        apply_ring_setup(24'hFFF000 | ($urandom & 24'hFFF), $urandom_range(1, MAX_CAPACITY),
                         $urandom_range(0, 511));
        run_random_phase(350, 1'b0);
        apply_ring_setup($urandom & 24'hFFFFFF, MAX_CAPACITY, 256);
        run_random_phase(300, 1'b0);

        // drain and let any stray result show up
        while (index_results_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d directed and %0d random requests over %0d register settings",
                 n_directed, n_random, n_settings);
        $display("checked %0d results: %0d with journal writes, %0d with wrapped segments",
                 n_checked, n_journal, n_wrapped);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
